>>> design/rme_pkg.sv
// Shared types and codes for the modular exponentiation block.
// No dependencies.
package rme_pkg;

	localparam int MOD_BITS_DEF = 32;
	localparam int VAL_W        = 32;
	localparam int EXP_W        = 32;

	typedef enum logic [1:0] {
		REG_MODULUS   = 2'd0,
		REG_PUB_EXP   = 2'd1,
		REG_PRIV_EXP  = 2'd2
	} reg_idx_t;

	localparam logic MODE_DECRYPT = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [VAL_W-1:0] value;
		logic             last_in;
	} rme_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] result_value;
		logic             last_out;
	} rme_out_t;

	// side info that rides along each item
	typedef struct packed {
		logic mode;
		logic last;
	} rme_ctl_t;

endpackage

>>> design/rme_red_cell.sv
// One step of the input reduction: shifts one value bit into the residue.
// Depends on rme_pkg.
module rme_red_cell #(
	parameter int W = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [W-1:0]             m,
	input  logic                     vld_i,
	input  rme_pkg::rme_ctl_t        ctl_i,
	input  logic [rme_pkg::VAL_W-1:0] val_i,
	input  logic [W-1:0]             r_i,
	output logic                     vld_o,
	output rme_pkg::rme_ctl_t        ctl_o,
	output logic [rme_pkg::VAL_W-1:0] val_o,
	output logic [W-1:0]             r_o
);
	import rme_pkg::*;

	logic [W:0] t;
	logic [W:0] t_red;

	always_comb begin
		t     = {r_i, val_i[VAL_W-1]};
		t_red = (t >= {1'b0, m}) ? (t - {1'b0, m}) : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o <= ctl_i;
			val_o <= {val_i[VAL_W-2:0], 1'b0};
			r_o   <= t_red[W-1:0];
		end
	end

endmodule

>>> design/rme_mul_cell.sv
// One step of the interleaved dual modular multiply (acc*sq and sq*sq).
// Depends on rme_pkg.
module rme_mul_cell #(
	parameter int W   = 32,
	parameter int BIT = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [W-1:0]      m,
	input  logic              ebit_pub,
	input  logic              ebit_priv,
	input  logic              vld_i,
	input  rme_pkg::rme_ctl_t ctl_i,
	input  logic [W-1:0]      acc_i,
	input  logic [W-1:0]      sq_i,
	input  logic [W-1:0]      ra_i,
	input  logic [W-1:0]      rs_i,
	output logic              vld_o,
	output rme_pkg::rme_ctl_t ctl_o,
	output logic [W-1:0]      acc_o,
	output logic [W-1:0]      sq_o,
	output logic [W-1:0]      ra_o,
	output logic [W-1:0]      rs_o
);
	import rme_pkg::*;

	localparam bit FIRST = (BIT == W - 1);
	localparam bit LAST  = (BIT == 0);

	// 2r + addend stays below 3m, so two conditional subtracts finish it
	function automatic logic [W-1:0] step(input logic [W-1:0] r, input logic [W-1:0] add,
		input logic [W-1:0] md);
		logic [W+1:0] t;
		logic [W+1:0] mm;
		begin
			mm = {2'b00, md};
			t  = {1'b0, r, 1'b0} + {2'b00, add};
			if (t >= mm) t = t - mm;
			if (t >= mm) t = t - mm;
			step = t[W-1:0];
		end
	endfunction

	logic [W-1:0] ra_b, rs_b;
	logic [W-1:0] ra_n, rs_n;
	logic         ebit;

	always_comb begin
		ra_b = FIRST ? '0 : ra_i;
		rs_b = FIRST ? '0 : rs_i;
		ra_n = step(ra_b, acc_i[BIT] ? sq_i : '0, m);
		rs_n = step(rs_b, sq_i[BIT] ? sq_i : '0, m);
		ebit = (ctl_i.mode == MODE_DECRYPT) ? ebit_priv : ebit_pub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o <= ctl_i;
			ra_o  <= ra_n;
			rs_o  <= rs_n;
			if (LAST) begin
				acc_o <= ebit ? ra_n : acc_i;
				sq_o  <= rs_n;
			end else begin
				acc_o <= acc_i;
				sq_o  <= sq_i;
			end
		end
	end

endmodule

>>> design/rsa_modular_exponentiation.sv
// Top level: pipelined value^e mod n, one item per cycle while the output is not stalled.
// Depends on rme_pkg, rme_red_cell, rme_mul_cell.
//
// channel | signals                           | transfer when
// --------+-----------------------------------+-------------------------
// input   | in_valid, in_ready, in_data       | in_valid && in_ready
// output  | out_valid, out_ready, out_data    | out_valid && out_ready
// config  | cfg_we, cfg_idx, cfg_wdata        | cfg_we
//
// Throughput: one item per cycle while the output is not stalled. W = min(MOD_BITS,32).
// Cell chain: 32 reduction cells, then W multiply cells per exponent bit, then the output register.
// Reset clears all valid bits; residues carry no reset.
// A stalled output freezes the whole chain; in_ready follows the output register.
module rsa_modular_exponentiation #(
	parameter int MOD_BITS = rme_pkg::MOD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rme_pkg::rme_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rme_pkg::rme_out_t out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [31:0]      cfg_wdata
);
	import rme_pkg::*;

	localparam int W  = (MOD_BITS < 32) ? MOD_BITS : 32;
	localparam int NM = EXP_W * W;

	logic [31:0]      modulus_q;
	logic [EXP_W-1:0] pub_q, priv_q;
	logic [W-1:0]     m;
	logic             adv;

	assign m   = modulus_q[W-1:0];
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// config registers, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 32'd2;
			pub_q     <= 32'd1;
			priv_q    <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODULUS:  modulus_q <= cfg_wdata;
				REG_PUB_EXP:  pub_q     <= cfg_wdata;
				REG_PRIV_EXP: priv_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// reduction chain: value mod m, msb first
	logic [VAL_W:0]   vld_r;
	rme_ctl_t         ctl_r [0:VAL_W];
	logic [VAL_W-1:0] val_r [0:VAL_W];
	logic [W-1:0]     r_r   [0:VAL_W];

	assign vld_r[0]      = in_valid;
	assign ctl_r[0].mode = in_data.mode;
	assign ctl_r[0].last = in_data.last_in;
	assign val_r[0]      = in_data.value;
	assign r_r[0]        = '0;

	for (genvar g = 0; g < VAL_W; g++) begin : g_red
		rme_red_cell #(.W(W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .m(m),
			.vld_i(vld_r[g]), .ctl_i(ctl_r[g]), .val_i(val_r[g]), .r_i(r_r[g]),
			.vld_o(vld_r[g+1]), .ctl_o(ctl_r[g+1]), .val_o(val_r[g+1]), .r_o(r_r[g+1])
		);
	end

	// multiply chain: W steps per exponent bit, lsb of exponent first
	logic [NM:0]  vld_m;
	rme_ctl_t     ctl_m [0:NM];
	logic [W-1:0] acc_m [0:NM];
	logic [W-1:0] sq_m  [0:NM];
	logic [W-1:0] ra_m  [0:NM];
	logic [W-1:0] rs_m  [0:NM];

	assign vld_m[0] = vld_r[VAL_W];
	assign ctl_m[0] = ctl_r[VAL_W];
	// 1 mod m: zero only for a modulus of one
	assign acc_m[0] = {{(W-1){1'b0}}, (m != W'(1))};
	assign sq_m[0]  = r_r[VAL_W];
	assign ra_m[0]  = '0;
	assign rs_m[0]  = '0;

	for (genvar n = 0; n < NM; n++) begin : g_mul
		rme_mul_cell #(.W(W), .BIT(W - 1 - (n % W))) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .m(m),
			.ebit_pub(pub_q[n / W]), .ebit_priv(priv_q[n / W]),
			.vld_i(vld_m[n]), .ctl_i(ctl_m[n]),
			.acc_i(acc_m[n]), .sq_i(sq_m[n]), .ra_i(ra_m[n]), .rs_i(rs_m[n]),
			.vld_o(vld_m[n+1]), .ctl_o(ctl_m[n+1]),
			.acc_o(acc_m[n+1]), .sq_o(sq_m[n+1]), .ra_o(ra_m[n+1]), .rs_o(rs_m[n+1])
		);
	end

	// output register; a zero modulus gives zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_m[NM];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.result_value <= (m == '0) ? '0 : VAL_W'(acc_m[NM]);
			out_data.last_out     <= ctl_m[NM].last;
		end
	end

	// chain holds still while the output stalls (in_valid itself may still rise)
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(vld_m) && $stable(vld_r[VAL_W:1])))
		else $error("cell chain moved during output stall");

	// a result never exceeds the residue width
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.result_value >> W) == '0))
		else $error("result wider than residue");

endmodule

>>> sim/rme_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the modular exponentiation block: tracks key writes, predicts
// value^exp mod n for each input transfer and compares output transfers in order.
// Depends on rme_pkg.
module rme_checker #(
	parameter int MOD_BITS = rme_pkg::MOD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  rme_pkg::rme_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  rme_pkg::rme_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [31:0]       cfg_wdata,
	output int                fails,
	output int                pending
);
	import rme_pkg::*;

	logic [31:0] key_mod, key_pub, key_priv;
	rme_out_t    expected_results[$];

	function automatic logic [31:0] mod_power(logic [31:0] base, logic [31:0] ex,
			logic [31:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		if (m == 0)
			return 0;
		acc = 64'd1 % m;
		sq  = base % m;
		for (int b = 0; b < 32; b++) begin
			if (ex[b])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
		end
		return acc[31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rme_out_t    pred;
		rme_out_t    want;
		logic [31:0] m_used;
		if (!arst_n) begin
			key_mod  <= 32'd2;
			key_pub  <= 32'd1;
			key_priv <= 32'd1;
			expected_results.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (in_valid && in_ready) begin
				m_used = (MOD_BITS >= 32) ? key_mod
					: key_mod & ((32'd1 << MOD_BITS) - 1);
				pred.result_value = mod_power(in_data.value,
					(in_data.mode == MODE_DECRYPT) ? key_priv : key_pub, m_used);
				pred.last_out = in_data.last_in;
				expected_results.push_back(pred);
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected output: actual %h/%b", $time,
						out_data.result_value, out_data.last_out);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (want.result_value !== out_data.result_value) begin
						$display("%0t: result_value mismatch: expected %h actual %h",
							$time, want.result_value, out_data.result_value);
						fails++;
					end
					if (want.last_out !== out_data.last_out) begin
						$display("%0t: last_out mismatch: expected %b actual %b",
							$time, want.last_out, out_data.last_out);
						fails++;
					end
				end
			end
			// key writes land after this edge's input transfer
			if (cfg_we) begin
				case (cfg_idx)
					REG_MODULUS:  key_mod  <= cfg_wdata;
					REG_PUB_EXP:  key_pub  <= cfg_wdata;
					REG_PRIV_EXP: key_priv <= cfg_wdata;
					default: ;
				endcase
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> sim/rsa_modular_exponentiation_tb.sv
`timescale 1ns / 100ps
// Top of the modular exponentiation testbench: clock, reset, key programming,
// stimulus and back-pressure. Depends on rme_pkg, rme_checker and the block.
module rsa_modular_exponentiation_tb;
	import rme_pkg::*;

	localparam int          LATENCY    = 32 + 32 * 32 + 1;
	localparam int          LIMIT      = 600000;
	localparam int          HOLD_LEN   = 3000;
	localparam int          RAND_ITEMS = 1750;
	// items per random key; long enough that the sender is still busy when a
	// held-off output finally freezes the chain
	localparam int          KEY_ITEMS  = RAND_ITEMS / 3;
	localparam logic [1:0]  REG_UNUSED = 2'd3;   // no register lives here

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready;
	rme_in_t     in_data;
	logic        out_valid, out_ready;
	rme_out_t    out_data;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [31:0] cfg_wdata;
	int          fails, pending;

	int          send_idle, recv_idle;   // percent of cycles each side sits out
	logic        hold_go, hold_done;
	int          hold_cnt;
	int          cycles;
	logic [31:0] cur_mod;

	rsa_modular_exponentiation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	rme_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// watchdog on total run length
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("rsa_modular_exponentiation test failed");
				$finish;
			end
		end
	end

	// Receiver: random ready, plus one long hold-off so the pipe fills
	// and in_ready drops while the sender keeps offering.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt  <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// One input transfer. valid only drops when a gap is taken, so back-to-back
	// items never see a low/high pair in the same step.
	task automatic send_item(logic mode, logic [31:0] value, logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		in_data.mode    <= mode;
		in_data.value   <= value;
		in_data.last_in <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Program a key set; the pipe is drained first.
	task automatic load_key(logic [31:0] m, logic [31:0] e, logic [31:0] d);
		drain();
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_MODULUS;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_idx   <= REG_PUB_EXP;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_idx   <= REG_PRIV_EXP;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mod = m;
	endtask

	// Mix of full-range values, ones near the modulus edges and ones near all-ones.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0:       return $urandom;
			1:       return (cur_mod != 0) ? $urandom % cur_mod : $urandom;
			2:       return $urandom_range(3);
			3:       return cur_mod - 1;
			4:       return cur_mod + $urandom_range(2);
			default: return 32'hFFFF_FFFF - $urandom_range(2);
		endcase
	endfunction

	task automatic set_pace(int sent);
		if (sent < RAND_ITEMS / 3) begin
			send_idle = 15;
			recv_idle = 52;
		end else if (sent < 2 * RAND_ITEMS / 3) begin
			send_idle = 52;
			recv_idle = 15;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	initial begin
		logic [31:0] m, e, d;
		int          sent;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_MODULUS;
		cfg_wdata = '0;
		hold_go   = 1'b0;
		hold_done = 1'b0;
		hold_cnt  = 0;
		send_idle = 15;
		recv_idle = 52;
		cur_mod   = 32'd2;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key (n=2, e=d=1) first
		send_item(1'b0, 32'd3, 1'b0);
		send_item(1'b1, 32'hFFFF_FFFF, 1'b1);

		// small textbook key, values around the modulus and the field extremes
		load_key(32'd3233, 32'd17, 32'd2753);
		send_item(1'b0, 32'd0, 1'b0);
		send_item(1'b1, 32'd1, 1'b0);
		send_item(1'b0, 32'd3232, 1'b0);
		send_item(1'b1, 32'd3233, 1'b1);       // equal to n, reduces to zero
		send_item(1'b0, 32'd3234, 1'b0);       // above n
		send_item(1'b1, 32'hFFFF_FFFF, 1'b1);
		send_item(1'b0, 32'd65, 1'b0);

		// largest key values everywhere
		load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(1'b0, 32'hFFFF_FFFE, 1'b0);
		send_item(1'b1, 32'hFFFF_FFFF, 1'b1);
		send_item(1'b0, 32'h8000_0000, 1'b0);

		// zero exponent on decrypt: result is one even for value zero
		load_key(32'hFFFF_FFFB, 32'd65537, 32'd0);
		send_item(1'b1, 32'd0, 1'b0);
		send_item(1'b1, 32'h1234_5678, 1'b1);
		send_item(1'b0, 32'h1234_5678, 1'b0);

		// modulus of one and of zero both give zero
		load_key(32'd1, 32'd5, 32'd7);
		send_item(1'b0, 32'd9, 1'b0);
		send_item(1'b1, 32'd0, 1'b1);
		load_key(32'd0, 32'd0, 32'd3);
		send_item(1'b0, 32'd9, 1'b0);
		send_item(1'b1, 32'hFFFF_FFFF, 1'b1);

		// write to the unused index must not disturb the key
		drain();
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_UNUSED;
		cfg_wdata <= 32'd77;
		@(posedge clk);
		cfg_we    <= 1'b0;
		send_item(1'b0, 32'd5, 1'b0);

		// random part: new key for every KEY_ITEMS items, a third of RAND_ITEMS rounded down
		sent = 0;
		while (sent < RAND_ITEMS) begin
			m = $urandom >> $urandom_range(30);
			if (m < 2)
				m = 2;
			e = $urandom >> $urandom_range(31);
			d = $urandom >> $urandom_range(31);
			load_key(m, e, d);
			for (int k = 0; k < KEY_ITEMS && sent < RAND_ITEMS; k++) begin
				set_pace(sent);
				if (sent == KEY_ITEMS)
					hold_go = 1'b1;
				send_item($urandom_range(1), pick_value(), ($urandom_range(7) == 0));
				sent++;
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 50) @(posedge clk);
		if (fails == 0)
			$display("rsa_modular_exponentiation test passed");
		else
			$display("rsa_modular_exponentiation test failed");
		$finish;
	end

endmodule

>>> filelist.f
design/rme_pkg.sv
design/rme_red_cell.sv
design/rme_mul_cell.sv
design/rsa_modular_exponentiation.sv
sim/rme_checker.sv
sim/rsa_modular_exponentiation_tb.sv
